// ===== design/ddq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ddq_pkg;

   localparam int BYTE_W = 8;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_type;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic     en;
      op_type   op;
      byte_type push_byte;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== design/ddq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ddq_req_if;
   import ddq_pkg::*;
   logic     valid;
   logic     ready;
   op_type   op;
   byte_type push_byte;

   modport source (output valid, output op, output push_byte, input ready);
   modport sink   (input valid, input op, input push_byte, output ready);
endinterface

interface ddq_rsp_if;
   import ddq_pkg::*;
   logic             valid;
   logic             ready;
   byte_type         popped_byte;
   byte_type         front_byte;
   byte_type         rear_byte;
   logic [OCC_W-1:0] occupancy;
   logic             is_empty;
   logic             is_full;
   status_type       status;

   modport source (output valid, output popped_byte, output front_byte, output rear_byte,
                   output occupancy, output is_empty, output is_full, output status,
                   input ready);
   modport sink   (input valid, input popped_byte, input front_byte, input rear_byte,
                   input occupancy, input is_empty, input is_full, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== design/ddq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddq_cell
   import ddq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire byte_type     left_data,
   input  wire logic         left_valid,
   input  wire byte_type     right_data,
   input  wire logic         right_valid,
   output      byte_type     data,
   output      logic         valid,
   output      byte_type     rear_tap
);

   byte_type data_ff, data_in;
   logic     valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.en) begin
         case (cmd.op)
            OP_PUSH_FRONT: begin
               data_in  = left_data;
               valid_in = left_valid;
            end
            OP_PUSH_REAR: begin
               if (!valid_ff && left_valid) begin
                  data_in  = cmd.push_byte;
                  valid_in = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               data_in  = right_data;
               valid_in = right_valid;
            end
            OP_POP_REAR: begin
               if (valid_ff && !right_valid) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data     = data_ff;
   assign valid    = valid_ff;
   assign rear_tap = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Channel   Dir  Beat fields
// req_chan  in   op, push_byte
// rsp_chan  out  popped_byte, front_byte, rear_byte, occupancy, is_empty, is_full, status
//
// The cell row shifts or loads in the accept cycle, and the result register loads
// from the row once the output register is free; req_chan.ready is low until then.
// A result waits in the output register while one more beat is accepted; that
// beat then holds until the register frees. Reset clears the valid bits of the
// cells, the busy flag, the count and the output valid; cell data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
   import ddq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   ddq_req_if.sink   req_chan,
   ddq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff;
   byte_type         popped_ff, popped_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff;
   byte_type         rsp_popped_ff, rsp_front_ff, rsp_rear_ff;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic             rsp_empty_ff, rsp_full_ff;
   status_type       rsp_status_ff;

   cell_cmd_type     cmd;
   byte_type         cell_data [DEPTH];
   logic             cell_valid [DEPTH];
   byte_type         rear_tap [DEPTH];
   byte_type         rear_byte, front_byte;
   logic             req_fire, load, is_push, q_full, q_empty;
   logic [CNT_W+OCC_W-1:0] count_ext;

   assign req_chan.ready = !busy_ff;
   assign req_fire       = req_chan.valid && !busy_ff;
   assign is_push        = (req_chan.op == OP_PUSH_FRONT) || (req_chan.op == OP_PUSH_REAR);
   assign q_full         = (count_ff == CNT_W'(DEPTH));
   assign q_empty        = (count_ff == '0);
   assign front_byte     = cell_valid[0] ? cell_data[0] : '0;

   always_comb begin
      rear_byte = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_byte = rear_byte | rear_tap[i];
      end
   end

   always_comb begin
      status_in = ST_OK;
      if (is_push && q_full) begin
         status_in = ST_PUSH_FULL;
      end else if (!is_push && q_empty) begin
         status_in = ST_POP_EMPTY;
      end
      cmd.en        = req_fire && (status_in == ST_OK);
      cmd.op        = req_chan.op;
      cmd.push_byte = req_chan.push_byte;
      count_in  = count_ff;
      popped_in = '0;
      if (cmd.en) begin
         case (req_chan.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: count_in = count_ff + CNT_W'(1);
            OP_POP_FRONT: begin
               count_in  = count_ff - CNT_W'(1);
               popped_in = cell_data[0];
            end
            OP_POP_REAR: begin
               count_in  = count_ff - CNT_W'(1);
               popped_in = rear_byte;
            end
            default: count_in = count_ff;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      byte_type ld, rd;
      logic     lv, rv;
      if (i == 0) begin : g_first
         assign ld = req_chan.push_byte;
         assign lv = 1'b1;
      end else begin : g_mid_l
         assign ld = cell_data[i-1];
         assign lv = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rd = '0;
         assign rv = 1'b0;
      end else begin : g_mid_r
         assign rd = cell_data[i+1];
         assign rv = cell_valid[i+1];
      end
      ddq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (ld),
         .left_valid  (lv),
         .right_data  (rd),
         .right_valid (rv),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .rear_tap    (rear_tap[i])
      );
   end

   assign load      = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign count_ext = {{OCC_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
      end
      if (load) begin
         rsp_popped_ff <= popped_ff;
         rsp_front_ff  <= front_byte;
         rsp_rear_ff   <= q_empty ? '0 : rear_byte;
         rsp_occ_ff    <= count_ext[OCC_W-1:0];
         rsp_empty_ff  <= q_empty;
         rsp_full_ff   <= q_full;
         rsp_status_ff <= status_ff;
      end
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (load) begin
            busy_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.popped_byte = rsp_popped_ff;
   assign rsp_chan.front_byte  = rsp_front_ff;
   assign rsp_chan.rear_byte   = rsp_rear_ff;
   assign rsp_chan.occupancy   = rsp_occ_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

`default_nettype wire

// ===== design/ddq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddq_checker
   import ddq_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire byte_type         rsp_popped_byte,
   input wire byte_type         rsp_front_byte,
   input wire logic [OCC_W-1:0] rsp_occupancy,
   input wire logic             rsp_is_empty,
   input wire logic             rsp_is_full,
   input wire status_type       rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_byte) && $stable(rsp_status))
      else $error("rsp beat dropped or changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_occupancy == '0 && rsp_front_byte == '0 && !rsp_is_full)
      else $error("empty flag disagrees with occupancy or front byte");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PUSH_FULL |-> rsp_is_full && rsp_popped_byte == '0)
      else $error("push dropped while queue not full");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_POP_EMPTY |-> rsp_is_empty && rsp_popped_byte == '0)
      else $error("pop refused while queue not empty");

endmodule

bind double_ended_queue ddq_checker u_ddq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_popped_byte (rsp_chan.popped_byte),
   .rsp_front_byte  (rsp_chan.front_byte),
   .rsp_occupancy   (rsp_chan.occupancy),
   .rsp_is_empty    (rsp_chan.is_empty),
   .rsp_is_full     (rsp_chan.is_full),
   .rsp_status      (rsp_chan.status)
);

`default_nettype wire

// ===== test/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_double_ended_queue;
   import ddq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int IDLE_LIMIT  = 4000;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      byte_type         popped_byte;
      byte_type         front_byte;
      byte_type         rear_byte;
      logic [OCC_W-1:0] occupancy;
      logic             is_empty;
      logic             is_full;
      status_type       status;
   } deque_view_type;

   class deque_scoreboard_type;
      byte_type       shadow_ring[DEPTH];
      int             shadow_head;
      int             shadow_count;
      deque_view_type expected_views[$];
      int             errors;

      function new();
         shadow_head  = 0;
         shadow_count = 0;
         errors       = 0;
         foreach (shadow_ring[i]) shadow_ring[i] = '0;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      // apply one operation to the shadow deque and queue the view it yields
      function void note_operation(op_type op, byte_type value);
         deque_view_type view;
         view        = '0;
         view.status = ST_OK;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (shadow_count >= DEPTH) begin
                  view.status = ST_PUSH_FULL;
               end else if (op == OP_PUSH_FRONT) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_ring[shadow_head] = value;
                  shadow_count++;
               end else begin
                  shadow_ring[(shadow_head + shadow_count) % DEPTH] = value;
                  shadow_count++;
               end
            end
            default: begin
               if (shadow_count == 0) begin
                  view.status = ST_POP_EMPTY;
               end else if (op == OP_POP_FRONT) begin
                  view.popped_byte = shadow_ring[shadow_head];
                  shadow_head = (shadow_head + 1) % DEPTH;
                  shadow_count--;
               end else begin
                  view.popped_byte = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
                  shadow_count--;
               end
            end
         endcase
         if (shadow_count != 0) begin
            view.front_byte = shadow_ring[shadow_head];
            view.rear_byte  = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
         end
         view.occupancy = shadow_count[OCC_W-1:0];
         view.is_empty  = (shadow_count == 0);
         view.is_full   = (shadow_count == DEPTH);
         expected_views.push_back(view);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_view(deque_view_type got);
         deque_view_type want;
         if (expected_views.size() == 0) begin
            $display("%0t: result beat with none expected, actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_views.pop_front();
         compare_field("popped_byte", want.popped_byte, got.popped_byte);
         compare_field("front_byte", want.front_byte, got.front_byte);
         compare_field("rear_byte", want.rear_byte, got.rear_byte);
         compare_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
         compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
         compare_field("is_full", 8'(want.is_full), 8'(got.is_full));
         compare_field("status", 8'(want.status), 8'(got.status));
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   idle_cycles = 0;

   deque_scoreboard_type sb;

   ddq_req_if req_chan ();
   ddq_rsp_if rsp_chan ();

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // note accepted requests before checking results on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_operation(req_chan.op, req_chan.push_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_view({rsp_chan.popped_byte, rsp_chan.front_byte, rsp_chan.rear_byte,
                           rsp_chan.occupancy, rsp_chan.is_empty, rsp_chan.is_full,
                           rsp_chan.status});
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_double_ended_queue NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_beat(input op_type op, input byte_type value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.push_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic run_directed();
      send_beat(OP_POP_FRONT, 8'hFF);
      send_beat(OP_POP_REAR, 8'h00);
      send_beat(OP_PUSH_REAR, 8'hFF);
      send_beat(OP_PUSH_FRONT, 8'h00);
      send_beat(OP_POP_FRONT, 8'h5A);
      send_beat(OP_POP_REAR, 8'hA5);
      // fill to capacity from both ends
      for (int i = 0; i < DEPTH; i++) begin
         send_beat(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, (i[1] ? 8'hAA : 8'h55) ^ 8'(i));
      end
      send_beat(OP_PUSH_FRONT, 8'hFF);
      send_beat(OP_PUSH_REAR, 8'h00);
      send_beat(OP_POP_FRONT, 8'h00);
      send_beat(OP_POP_REAR, 8'hFF);
   endtask

   task automatic run_random(input int count);
      int     push_pct;
      op_type op;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         // swing between filling and draining so both full and empty are hit
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
         end
         send_beat(op, byte_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      sb                 = new();
      reset              = 1'b1;
      send_idle_pct      = 36;
      recv_stall_pct     = 66;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_PUSH_FRONT;
      req_chan.push_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_ITEMS);
      send_idle_pct  = 66;
      recv_stall_pct = 36;
      run_random(PHASE_ITEMS);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_double_ended_queue OK");
      end else begin
         $display("tb_double_ended_queue NOT OK");
      end
      $finish;
   end

endmodule
